/* hdl/pxacc_pkg.sv */
// Shared constants, codes and types of the Paxos acceptor.
package pxacc_pkg;

	localparam int WINDOW   = 64;
	localparam int TAG_BITS = 16;
	localparam int IDX_W    = $clog2(WINDOW);
	localparam int SUM_W    = IDX_W + 1;

	localparam logic [1:0] ACT_PREPARE = 2'd0;
	localparam logic [1:0] ACT_ACCEPT  = 2'd1;
	localparam logic [1:0] ACT_COMMIT  = 2'd2;
	localparam logic [1:0] ACT_NONE    = 2'd3;

	localparam logic [1:0] KIND_PREPARE = 2'd0;
	localparam logic [1:0] KIND_ACCEPT  = 2'd1;
	localparam logic [1:0] KIND_HELD    = 2'd2;
	localparam logic [1:0] KIND_EXEC    = 2'd3;

	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic [31:0]         seen;
		logic [31:0]         accepted;
		logic [TAG_BITS-1:0] tag;
	} entry_t;

	typedef struct packed {
		logic   rd_en;
		idx_t   rd_idx;
		logic   wr_en;
		logic   wr_commit;
		idx_t   wr_idx;
		entry_t wr_data;
		logic   clr_en;
		idx_t   clr_idx;
	} store_cmd_t;

endpackage

/* hdl/pxacc_req_if.sv */
// Request channel: one acceptor message per transfer.
interface pxacc_req_if import pxacc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [1:0]          action;
	logic [31:0]         slot;
	logic [31:0]         ballot;
	logic [TAG_BITS-1:0] command_tag;

	modport source (output valid, output action, output slot, output ballot,
		output command_tag, input ready);
	modport sink (input valid, input action, input slot, input ballot,
		input command_tag, output ready);
endinterface

/* hdl/pxacc_rsp_if.sv */
// Reply channel: one acceptor result per transfer.
interface pxacc_rsp_if import pxacc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [1:0]          reply_kind;
	logic                granted;
	logic [31:0]         highest_ballot;
	logic [31:0]         executed_slot;
	logic [TAG_BITS-1:0] executed_command;
	logic                last;

	modport source (output valid, output reply_kind, output granted,
		output highest_ballot, output executed_slot, output executed_command,
		output last, input ready);
	modport sink (input valid, input reply_kind, input granted,
		input highest_ballot, input executed_slot, input executed_command,
		input last, output ready);
endinterface

/* hdl/pxacc_store.sv */
// Slot entry store: entry memory with registered read, valid and committed flags.
module pxacc_store import pxacc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  store_cmd_t        cmd,
	output entry_t            rd_data,
	output logic [WINDOW-1:0] committed
);

	entry_t            mem [WINDOW];
	entry_t            rd_q;
	logic              rd_valid_q;
	logic [WINDOW-1:0] valid_q;
	logic [WINDOW-1:0] committed_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en)
			mem[cmd.wr_idx] <= cmd.wr_data;
		if (cmd.rd_en)
			rd_q <= mem[cmd.rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			committed_q <= '0;
			rd_valid_q  <= 1'b0;
		end else begin
			if (cmd.rd_en)
				rd_valid_q <= valid_q[cmd.rd_idx];
			if (cmd.wr_en) begin
				valid_q[cmd.wr_idx] <= 1'b1;
				if (cmd.wr_commit)
					committed_q[cmd.wr_idx] <= 1'b1;
			end
			if (cmd.clr_en) begin
				valid_q[cmd.clr_idx]     <= 1'b0;
				committed_q[cmd.clr_idx] <= 1'b0;
			end
		end
	end

	// entries never written since reset or release read as zero
	assign rd_data   = rd_valid_q ? rd_q : '0;
	assign committed = committed_q;

endmodule

/* hdl/paxos_acceptor_in_order_commit.sv */
// Multi-Paxos acceptor over a window of log slots with in-order commit release.
// Flow: an item is taken in IDLE and its entry is read from the entry memory
// (registered read); prepare and accept reply from EXEC, where the read data is
// ready, once the output register is free. A commit writes its entry in EXEC,
// checks the next slot to run in REL_CHK, then in REL_OUT releases one committed
// slot per cycle while the output register is free (one memory read each), or
// gives only the held reply from REL_CHK when nothing can be released. A reply waiting in
// the output register does not block taking the next item; the block stalls
// only when a new reply is due and the previous one is still untaken.
module paxos_acceptor_in_order_commit import pxacc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	pxacc_req_if.sink  req,
	pxacc_rsp_if.source rsp
);

	typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_REL_CHK, ST_REL_OUT} state_t;

	state_t              state_q;
	logic [1:0]          act_q;
	logic [31:0]         slot_q;
	logic [31:0]         ballot_q;
	logic [TAG_BITS-1:0] tag_q;
	logic                win_q;
	idx_t                idx_q;
	logic [31:0]         le_q;
	idx_t                le_idx_q;
	logic [31:0]         hc_q;

	logic                out_valid_q;
	logic [1:0]          out_kind_q;
	logic                out_granted_q;
	logic [31:0]         out_ballot_q;
	logic [31:0]         out_slot_q;
	logic [TAG_BITS-1:0] out_cmd_q;
	logic                out_last_q;

	store_cmd_t          cmd;
	entry_t              rd_data;
	logic [WINDOW-1:0]   committed;

	logic                accept_in;
	logic                out_free;
	logic                out_load;
	logic [31:0]         slot_off;
	logic                win_in;
	logic [SUM_W-1:0]    idx_sum;
	idx_t                idx_in;
	logic [31:0]         rel_id;
	idx_t                rel_idx;
	idx_t                nxt_idx;
	logic [31:0]         nxt_id;
	logic                rel_go;
	logic                nxt_go;
	logic                prep_ok;
	logic                acc_ok;

	pxacc_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.rd_data   (rd_data),
		.committed (committed)
	);

	assign req.ready = (state_q == ST_IDLE);
	assign accept_in = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;

	// window is le+1 .. le+WINDOW; entry index tracked relative to le
	always_comb begin
		slot_off = req.slot - le_q;
		win_in   = (slot_off != 32'd0) && (slot_off <= 32'(WINDOW));
		idx_sum  = {1'b0, le_idx_q} + slot_off[SUM_W-1:0];
		if (idx_sum >= SUM_W'(WINDOW))
			idx_sum = idx_sum - SUM_W'(WINDOW);
		idx_in   = idx_sum[IDX_W-1:0];
	end

	always_comb begin
		rel_id  = le_q + 32'd1;
		rel_idx = (le_idx_q == idx_t'(WINDOW - 1)) ? '0 : le_idx_q + idx_t'(1);
		nxt_idx = (rel_idx == idx_t'(WINDOW - 1)) ? '0 : rel_idx + idx_t'(1);
		nxt_id  = le_q + 32'd2;
		rel_go  = (rel_id <= hc_q) && committed[rel_idx];
		nxt_go  = (nxt_id <= hc_q) && committed[nxt_idx];
		prep_ok = ballot_q > rd_data.seen;
		acc_ok  = ballot_q >= rd_data.seen;
	end

	always_comb begin
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE:    out_load = 1'b0;
			ST_EXEC:    out_load = out_free && (act_q != ACT_NONE) &&
				!(win_q && act_q == ACT_COMMIT);
			ST_REL_CHK: out_load = out_free && !rel_go;
			ST_REL_OUT: out_load = out_free;
			default:    out_load = 1'b0;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.rd_en  = accept_in;
				cmd.rd_idx = idx_in;
			end
			ST_EXEC: begin
				cmd.wr_idx  = idx_q;
				cmd.wr_data = rd_data;
				if (win_q) begin
					priority if (act_q == ACT_PREPARE) begin
						cmd.wr_en        = out_free && prep_ok;
						cmd.wr_data.seen = ballot_q;
					end else if (act_q == ACT_ACCEPT) begin
						cmd.wr_en            = out_free && acc_ok;
						cmd.wr_data.seen     = ballot_q;
						cmd.wr_data.accepted = ballot_q;
					end else if (act_q == ACT_COMMIT) begin
						cmd.wr_en       = 1'b1;
						cmd.wr_commit   = 1'b1;
						cmd.wr_data.tag = tag_q;
					end else begin
						cmd.wr_en = 1'b0;
					end
				end
			end
			ST_REL_CHK: begin
				cmd.rd_en  = rel_go;
				cmd.rd_idx = rel_idx;
			end
			ST_REL_OUT: begin
				cmd.clr_en  = out_free;
				cmd.clr_idx = rel_idx;
				cmd.rd_en   = out_free && nxt_go;
				cmd.rd_idx  = nxt_idx;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			act_q         <= ACT_NONE;
			slot_q        <= '0;
			ballot_q      <= '0;
			tag_q         <= '0;
			win_q         <= 1'b0;
			idx_q         <= '0;
			le_q          <= '0;
			le_idx_q      <= '0;
			hc_q          <= '0;
			out_valid_q   <= 1'b0;
			out_kind_q    <= KIND_PREPARE;
			out_granted_q <= 1'b0;
			out_ballot_q  <= '0;
			out_slot_q    <= '0;
			out_cmd_q     <= '0;
			out_last_q    <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && rsp.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept_in) begin
						act_q    <= req.action;
						slot_q   <= req.slot;
						ballot_q <= req.ballot;
						tag_q    <= req.command_tag;
						win_q    <= win_in;
						idx_q    <= idx_in;
						state_q  <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (act_q == ACT_NONE) begin
						state_q <= ST_IDLE;
					end else if (win_q && act_q == ACT_COMMIT) begin
						if (slot_q > hc_q)
							hc_q <= slot_q;
						state_q <= ST_REL_CHK;
					end else if (out_free) begin
						out_kind_q    <= act_q;
						out_slot_q    <= '0;
						out_cmd_q     <= '0;
						out_last_q    <= 1'b1;
						if (!win_q) begin
							out_granted_q <= 1'b0;
							out_ballot_q  <= '0;
						end else if (act_q == ACT_PREPARE) begin
							out_granted_q <= prep_ok;
							out_ballot_q  <= prep_ok ? ballot_q : rd_data.seen;
						end else begin
							out_granted_q <= acc_ok;
							out_ballot_q  <= acc_ok ? ballot_q : rd_data.seen;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_REL_CHK: begin
					if (rel_go) begin
						state_q <= ST_REL_OUT;
					end else if (out_free) begin
						// nothing to release: held reply with the slot's seen ballot
						out_kind_q    <= KIND_HELD;
						out_granted_q <= 1'b1;
						out_ballot_q  <= rd_data.seen;
						out_slot_q    <= '0;
						out_cmd_q     <= '0;
						out_last_q    <= 1'b1;
						state_q       <= ST_IDLE;
					end
				end
				ST_REL_OUT: begin
					if (out_free) begin
						out_kind_q    <= KIND_EXEC;
						out_granted_q <= 1'b1;
						out_ballot_q  <= rd_data.seen;
						out_slot_q    <= rel_id;
						out_cmd_q     <= rd_data.tag;
						out_last_q    <= !nxt_go;
						le_q          <= rel_id;
						le_idx_q      <= rel_idx;
						if (!nxt_go)
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.reply_kind       = out_kind_q;
	assign rsp.granted          = out_granted_q;
	assign rsp.highest_ballot   = out_ballot_q;
	assign rsp.executed_slot    = out_slot_q;
	assign rsp.executed_command = out_cmd_q;
	assign rsp.last             = out_last_q;

endmodule

/* tb/paxos_acceptor_in_order_commit_test.sv */
// Self-checking testbench for the Paxos acceptor: prepare/accept/commit traffic, in-order release.
module paxos_acceptor_in_order_commit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import pxacc_pkg::*;

	localparam int QUIET_LIMIT     = 4000;
	localparam int ITEMS_PER_PHASE = 90;
	localparam int DRAIN_CYCLES    = 100;

	typedef struct packed {
		logic [1:0]          kind;
		logic                granted;
		logic [31:0]         ballot;
		logic [31:0]         slot;
		logic [TAG_BITS-1:0] command;
		logic                last;
	} reply_t;

	class acceptor_scoreboard;
		logic [31:0]         seen [WINDOW];
		logic [31:0]         accepted [WINDOW];
		bit                  committed [WINDOW];
		logic [TAG_BITS-1:0] tag [WINDOW];
		logic [31:0]         last_exec;
		logic [31:0]         top_commit;
		reply_t              pending [$];
		int                  errors;
		int                  requests;
		int                  ignored;
		int                  replies;
		int                  released;
		int                  held;
		int                  rejected;
		int                  longest_run;

		function new();
			foreach (seen[i]) begin
				seen[i] = '0;
				accepted[i] = '0;
				committed[i] = 1'b0;
				tag[i] = '0;
			end
			last_exec = '0;
			top_commit = '0;
			errors = 0;
			requests = 0;
			ignored = 0;
			replies = 0;
			released = 0;
			held = 0;
			rejected = 0;
			longest_run = 0;
		endfunction

		function reply_t pack_reply(logic [1:0] kind, logic granted, logic [31:0] ballot,
			logic [31:0] slot, logic [TAG_BITS-1:0] command, logic last);
			reply_t r;
			r.kind = kind;
			r.granted = granted;
			r.ballot = ballot;
			r.slot = slot;
			r.command = command;
			r.last = last;
			return r;
		endfunction

		function void queue_reply(reply_t r);
			pending = {pending, r};
		endfunction

		// Advance the acceptor state for one request and queue the replies it causes.
		function void note_request(logic [1:0] act, logic [31:0] slot, logic [31:0] ballot,
			logic [TAG_BITS-1:0] cmd);
			logic [31:0] offset;
			logic [31:0] nxt;
			idx_t        e;
			idx_t        x;
			logic        ok;
			int          n;
			offset = slot - last_exec;
			e = idx_t'(slot % WINDOW);
			n = 0;
			if (act == ACT_NONE) begin
				ignored++;
				return;
			end
			requests++;
			if (offset == 0 || offset > WINDOW) begin
				rejected++;
				queue_reply(pack_reply(act, 1'b0, '0, '0, '0, 1'b1));
				return;
			end
			if (act == ACT_PREPARE) begin
				ok = ballot > seen[e];
				if (ok)
					seen[e] = ballot;
				else
					rejected++;
				queue_reply(pack_reply(KIND_PREPARE, ok, seen[e], '0, '0, 1'b1));
				return;
			end
			if (act == ACT_ACCEPT) begin
				ok = ballot >= seen[e];
				if (ok) begin
					seen[e] = ballot;
					accepted[e] = ballot;
				end else begin
					rejected++;
				end
				queue_reply(pack_reply(KIND_ACCEPT, ok, seen[e], '0, '0, 1'b1));
				return;
			end
			tag[e] = cmd;
			committed[e] = 1'b1;
			if (slot > top_commit)
				top_commit = slot;
			while (n < WINDOW) begin
				nxt = last_exec + 32'd1;
				x = idx_t'(nxt % WINDOW);
				if (nxt > top_commit || !committed[x])
					break;
				queue_reply(pack_reply(KIND_EXEC, 1'b1, seen[x], nxt, tag[x], 1'b0));
				seen[x] = '0;
				accepted[x] = '0;
				committed[x] = 1'b0;
				tag[x] = '0;
				last_exec = nxt;
				n++;
			end
			if (n == 0) begin
				held++;
				queue_reply(pack_reply(KIND_HELD, 1'b1, seen[e], '0, '0, 1'b1));
			end else begin
				pending[pending.size()-1].last = 1'b1;
				released += n;
				if (n > longest_run)
					longest_run = n;
			end
		endfunction

		function void compare(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$error("%s mismatch: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_reply(reply_t got);
			reply_t want;
			replies++;
			if (pending.size() == 0) begin
				$error("unexpected reply: kind %0d slot %0h", got.kind, got.slot);
				errors++;
				return;
			end
			want = pending.pop_front();
			compare("reply_kind", want.kind, got.kind);
			compare("granted", want.granted, got.granted);
			compare("highest_ballot", want.ballot, got.ballot);
			compare("executed_slot", want.slot, got.slot);
			compare("executed_command", want.command, got.command);
			compare("last", want.last, got.last);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   idle_pct;
	int   stall_pct;

	acceptor_scoreboard sb = new();

	pxacc_req_if req_ch ();
	pxacc_rsp_if rsp_ch ();

	paxos_acceptor_in_order_commit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [31:0] next_ballot();
		case ($urandom_range(9))
			0: return $urandom;
			1: return 32'hFFFF_FFFF;
			2: return 32'd0;
			default: return $urandom_range(1, 60);
		endcase
	endfunction

	function automatic logic [TAG_BITS-1:0] rand_tag();
		return TAG_BITS'($urandom);
	endfunction

	task automatic send(input logic [1:0] act, input logic [31:0] slot,
		input logic [31:0] ballot, input logic [TAG_BITS-1:0] cmd);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			req_ch.valid = 1'b0;
		end
		@(negedge clk);
		req_ch.valid = 1'b1;
		req_ch.action = act;
		req_ch.slot = slot;
		req_ch.ballot = ballot;
		req_ch.command_tag = cmd;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		sb.note_request(act, slot, ballot, cmd);
	endtask

	task automatic run_directed();
		send(ACT_PREPARE, 32'd1, 32'd5, '0);
		send(ACT_PREPARE, 32'd1, 32'd5, '0);
		send(ACT_PREPARE, 32'd1, 32'd3, '0);
		send(ACT_ACCEPT, 32'd1, 32'd5, '0);
		send(ACT_ACCEPT, 32'd1, 32'd4, '0);
		send(ACT_ACCEPT, 32'd1, 32'hFFFF_FFFF, '0);
		send(ACT_PREPARE, 32'd1, 32'hFFFF_FFFF, '0);
		send(ACT_PREPARE, 32'd0, 32'd1, '0);
		send(ACT_PREPARE, 32'd65, 32'd1, '0);
		send(ACT_ACCEPT, 32'd64, 32'd0, '0);
		send(ACT_PREPARE, 32'd64, 32'd0, '0);
		send(ACT_ACCEPT, 32'hFFFF_FFFF, 32'd7, '1);
		send(ACT_COMMIT, 32'd0, 32'd0, 16'h1234);
		send(ACT_NONE, $urandom, $urandom, rand_tag());
		send(ACT_COMMIT, 32'd3, 32'd0, '1);
		send(ACT_PREPARE, 32'd2, 32'h8000_0000, '0);
		send(ACT_COMMIT, 32'd2, 32'd0, '0);
		send(ACT_COMMIT, 32'd64, 32'd0, 16'h5A5A);
		// fills the gap at slot 1: slots 1..3 go out in order
		send(ACT_COMMIT, 32'd1, 32'hFFFF_FFFF, 16'hABCD);
		send(ACT_COMMIT, 32'd3, 32'd0, 16'h0F0F);
		send(ACT_PREPARE, 32'd67, 32'd9, '0);
		send(ACT_PREPARE, 32'd68, 32'd9, '0);
		send(ACT_COMMIT, 32'd4, 32'd2, 16'h8001);
	endtask

	// Commit slots last+2..last+n in random order, then last+1 to release the whole run.
	task automatic commit_burst(input int n);
		logic [31:0] order [$];
		logic [31:0] base;
		logic [31:0] t;
		int          j;
		base = sb.last_exec;
		for (int i = 2; i <= n; i++)
			order = {order, base + 32'(i)};
		for (int i = order.size() - 1; i > 0; i--) begin
			j = $urandom_range(i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		foreach (order[i])
			send(ACT_COMMIT, order[i], next_ballot(), rand_tag());
		send(ACT_COMMIT, base + 32'd1, next_ballot(), rand_tag());
	endtask

	task automatic random_step();
		int          pick;
		logic [31:0] s;
		logic [31:0] b;
		pick = $urandom_range(99);
		if (pick < 40) begin
			s = sb.last_exec + 32'd1 +
				(($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(3));
			b = next_ballot();
			send(ACT_PREPARE, s, b, rand_tag());
			if ($urandom_range(3) != 0)
				send(ACT_ACCEPT, s, ($urandom_range(4) == 0) ? next_ballot() : b, rand_tag());
			if ($urandom_range(4) != 0)
				send(ACT_COMMIT, s, b, rand_tag());
		end else if (pick < 52) begin
			commit_burst(($urandom_range(15) == 0) ? WINDOW : $urandom_range(2, 8));
		end else if (pick < 82) begin
			s = sb.last_exec + 32'd1 + $urandom_range(WINDOW - 1);
			send(2'($urandom_range(2)), s, next_ballot(), rand_tag());
		end else if (pick < 95) begin
			case ($urandom_range(3))
				0: s = sb.last_exec - $urandom_range(5);
				1: s = sb.last_exec + WINDOW + 1 + $urandom_range(100);
				2: s = $urandom;
				default: s = $urandom | 32'h8000_0000;
			endcase
			send(2'($urandom_range(2)), s, next_ballot(), rand_tag());
		end else begin
			send(ACT_NONE, $urandom, $urandom, rand_tag());
		end
	endtask

	// reply side: ready changes at the falling edge, transfers are taken at the rising edge
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_ch.ready = ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready)
				sb.check_reply(sb.pack_reply(rsp_ch.reply_kind, rsp_ch.granted,
					rsp_ch.highest_ballot, rsp_ch.executed_slot,
					rsp_ch.executed_command, rsp_ch.last));
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int base;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.action = ACT_PREPARE;
		req_ch.slot = '0;
		req_ch.ballot = '0;
		req_ch.command_tag = '0;
		idle_pct = 0;
		stall_pct = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		run_directed();
		base = sb.requests;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 71; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 71; end
				default: begin idle_pct = 32; stall_pct = 32; end
			endcase
			while (sb.requests < base + (phase + 1) * ITEMS_PER_PHASE)
				random_step();
		end
		@(negedge clk);
		req_ch.valid = 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run: %0d requests (%0d ignored), %0d replies, %0d rejected, %0d held",
			sb.requests, sb.ignored, sb.replies, sb.rejected, sb.held);
		$display("Run: %0d slots executed in order, longest release run %0d slots",
			sb.released, sb.longest_run);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
